FILE: design/sap1_pkg.sv
// Shared types and constants for the SAP-1 T-state core.
package sap1_pkg;

  // Request codes carried in req_type; the spare code is ignored.
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_RESTART = 2'd2
  } sap1_req_e;

  // Opcodes in the high nibble of the instruction byte.
  localparam logic [3:0] OP_LDA = 4'h0;
  localparam logic [3:0] OP_ADD = 4'h1;
  localparam logic [3:0] OP_SUB = 4'h2;
  localparam logic [3:0] OP_OUT = 4'hE;
  localparam logic [3:0] OP_HLT = 4'hF;

  localparam int unsigned MemDepth = 16;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] mem_address;
    logic [7:0] mem_data;
  } sap1_req_t;

  typedef struct packed {
    logic [3:0] pc_value;
    logic [3:0] mar_value;
    logic [7:0] ir_value;
    logic [7:0] acc_value;
    logic [7:0] b_value;
    logic [7:0] out_value;
    logic       cpu_running;
    logic [2:0] phase;
  } sap1_snap_t;

endpackage

FILE: design/sap1_if.sv
// Request and response channel interfaces for the SAP-1 T-state core.
interface sap1_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] mem_address;
  logic [7:0] mem_data;

  modport source (output valid, req_type, mem_address, mem_data, input ready);
  modport sink (input valid, req_type, mem_address, mem_data, output ready);
endinterface

interface sap1_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] pc_value;
  logic [3:0] mar_value;
  logic [7:0] ir_value;
  logic [7:0] acc_value;
  logic [7:0] b_value;
  logic [7:0] out_value;
  logic       cpu_running;
  logic [2:0] phase;

  modport source (
    output valid, pc_value, mar_value, ir_value, acc_value, b_value, out_value,
           cpu_running, phase,
    input  ready
  );
  modport sink (
    input  valid, pc_value, mar_value, ir_value, acc_value, b_value, out_value,
           cpu_running, phase,
    output ready
  );
endinterface

FILE: design/sap1_exec.sv
// Architectural registers, program memory and the T-state sequencer.
module sap1_exec
  import sap1_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  sap1_req_t  req_i,
  output sap1_snap_t snap_o
);

  typedef enum logic [2:0] {
    T1 = 3'd0,
    T2 = 3'd1,
    T3 = 3'd2,
    T4 = 3'd3,
    T5 = 3'd4
  } tstate_e;

  tstate_e    tstate_q, tstate_d;
  logic [3:0] pc_q, pc_d;
  logic [3:0] mar_q, mar_d;
  logic [7:0] ir_q, ir_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] b_q, b_d;
  logic [7:0] out_q, out_d;
  logic       run_q, run_d;
  logic [7:0] mem_q [MemDepth];
  logic [7:0] rd_data;
  logic [3:0] opc;
  logic [3:0] opnd;

  assign rd_data = mem_q[mar_q];
  assign opc     = ir_q[7:4];
  assign opnd    = ir_q[3:0];

  always_comb begin
    tstate_d = tstate_q;
    pc_d     = pc_q;
    mar_d    = mar_q;
    ir_d     = ir_q;
    acc_d    = acc_q;
    b_d      = b_q;
    out_d    = out_q;
    run_d    = run_q;
    case (req_i.req_type)
      REQ_TICK: begin
        if (run_q) begin
          unique case (tstate_q)
            T1: begin
              mar_d    = pc_q;
              tstate_d = T2;
            end
            T2: begin
              ir_d     = rd_data;
              pc_d     = pc_q + 4'd1;
              tstate_d = T3;
            end
            T3: tstate_d = T4;
            T4: begin
              if (opc == OP_HLT) begin
                // stop here; the sequencer stays at T4
                run_d = 1'b0;
              end else begin
                if (opc == OP_LDA || opc == OP_ADD || opc == OP_SUB) mar_d = opnd;
                if (opc == OP_OUT) out_d = acc_q;
                tstate_d = T5;
              end
            end
            T5: begin
              unique case (opc)
                OP_LDA: acc_d = rd_data;
                OP_ADD: begin
                  b_d   = rd_data;
                  acc_d = acc_q + rd_data;
                end
                OP_SUB: begin
                  b_d   = rd_data;
                  acc_d = acc_q - rd_data;
                end
                default: ;
              endcase
              tstate_d = T1;
            end
            default: tstate_d = T1;
          endcase
        end
      end
      REQ_RESTART: begin
        tstate_d = T1;
        pc_d     = '0;
        mar_d    = '0;
        ir_d     = '0;
        acc_d    = '0;
        b_d      = '0;
        out_d    = '0;
        run_d    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstate_q <= T1;
      pc_q     <= '0;
      mar_q    <= '0;
      ir_q     <= '0;
      acc_q    <= '0;
      b_q      <= '0;
      out_q    <= '0;
      run_q    <= 1'b1;
    end else if (step_i) begin
      tstate_q <= tstate_d;
      pc_q     <= pc_d;
      mar_q    <= mar_d;
      ir_q     <= ir_d;
      acc_q    <= acc_d;
      b_q      <= b_d;
      out_q    <= out_d;
      run_q    <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MemDepth; i++) mem_q[i] <= '0;
    end else if (step_i && req_i.req_type == REQ_WRITE) begin
      mem_q[req_i.mem_address] <= req_i.mem_data;
    end
  end

  // Report the state as it stands after this item.
  always_comb begin
    snap_o.pc_value    = pc_d;
    snap_o.mar_value   = mar_d;
    snap_o.ir_value    = ir_d;
    snap_o.acc_value   = acc_d;
    snap_o.b_value     = b_d;
    snap_o.out_value   = out_d;
    snap_o.cpu_running = run_d;
    snap_o.phase       = tstate_d;
  end

endmodule

FILE: design/sap1_cpu_tstate_core.sv
// Top level of the SAP-1 T-state core: request register, execute step, response register.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  req_i   | in  | req_type, mem_address, mem_data (tick, memory write, restart)
//  rsp_o   | out | pc, mar, ir, acc, b, out, cpu_running, phase after the beat
//
// Every request beat yields exactly one response beat. A beat waits in the request
// register, then passes through the execute step into the response register.
// Throughput is one beat per cycle while the response is not stalled, set by the single
// register-file update in the execute step. Reset clears the valid flags and the
// architectural registers, sets the run flag and zeroes the 16-byte program memory at
// once. A stalled response holds the response register; the request register still drains into it once it frees.
module sap1_cpu_tstate_core
  import sap1_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  sap1_req_if.sink  req_i,
  sap1_rsp_if.source rsp_o
);

  logic       in_valid_q;
  sap1_req_t  in_q;
  logic       out_valid_q;
  sap1_snap_t out_q;
  sap1_snap_t snap;
  logic       advance;
  logic       req_fire;

  // Move the held request into the response register when that slot is free.
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold unless a new beat lands.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_q.req_type    <= req_i.req_type;
      in_q.mem_address <= req_i.mem_address;
      in_q.mem_data    <= req_i.mem_data;
    end
    if (advance) begin
      out_q <= snap;
    end
  end

  sap1_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (in_q),
    .snap_o (snap)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pc_value    = out_q.pc_value;
  assign rsp_o.mar_value   = out_q.mar_value;
  assign rsp_o.ir_value    = out_q.ir_value;
  assign rsp_o.acc_value   = out_q.acc_value;
  assign rsp_o.b_value     = out_q.b_value;
  assign rsp_o.out_value   = out_q.out_value;
  assign rsp_o.cpu_running = out_q.cpu_running;
  assign rsp_o.phase       = out_q.phase;

endmodule

FILE: design/sap1_chk.sv
// Port-level checks on the SAP-1 T-state core, bound to the top level.
module sap1_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [3:0] pc_value_i,
  input logic [3:0] mar_value_i,
  input logic       cpu_running_i,
  input logic [2:0] phase_i
);

  localparam logic [2:0] PhaseT2 = 3'd1;
  localparam logic [2:0] PhaseT3 = 3'd2;
  localparam logic [2:0] PhaseT4 = 3'd3;

  // A halted core always sits at T4.
  a_halt_at_t4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !cpu_running_i) |-> (phase_i == PhaseT4))
    else $error("halted outside T4");

  // Right after T1, the address register mirrors the program counter.
  a_t2_mar_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && phase_i == PhaseT2) |-> (mar_value_i == pc_value_i))
    else $error("MAR differs from PC at T2");

  // After the fetch, the program counter is one past the fetch address.
  a_t3_pc_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && phase_i == PhaseT3) |-> (pc_value_i == mar_value_i + 4'd1))
    else $error("PC not advanced after fetch");

  // A stalled response beat holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(pc_value_i) && $stable(mar_value_i) && $stable(phase_i)))
    else $error("stalled response changed");

endmodule

bind sap1_cpu_tstate_core sap1_chk u_sap1_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .pc_value_i    (rsp_o.pc_value),
  .mar_value_i   (rsp_o.mar_value),
  .cpu_running_i (rsp_o.cpu_running),
  .phase_i       (rsp_o.phase)
);

FILE: tb/sap1_snapshot_checker.sv
`timescale 1ns / 100ps
// Scoreboard that predicts SAP-1 register snapshots and checks every response beat.
module sap1_snapshot_checker
  import sap1_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sap1_req_if  req_mon,
  sap1_rsp_if  rsp_mon,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o
);

  localparam logic [2:0] T1 = 3'd0;
  localparam logic [2:0] T2 = 3'd1;
  localparam logic [2:0] T3 = 3'd2;
  localparam logic [2:0] T4 = 3'd3;
  localparam logic [2:0] T5 = 3'd4;
  localparam int MaxReports = 30;

  logic [3:0] pc_q;
  logic [3:0] mar_q;
  logic [7:0] ir_q;
  logic [7:0] acc_q;
  logic [7:0] b_q;
  logic [7:0] out_q;
  logic       run_q;
  logic [2:0] tstate_q;
  logic [7:0] mem_q [MemDepth];

  sap1_snap_t snapshots_due[$];
  int         mismatch_count;
  int         snapshot_count;

  assign mismatches_o = mismatch_count;
  assign pending_o    = snapshots_due.size();
  assign checked_o    = snapshot_count;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MaxReports) begin
      $display("%0t: snapshot %0d: %s got 0x%0h, want 0x%0h",
               $realtime, snapshot_count, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic void clear_cpu();
    pc_q     = '0;
    mar_q    = '0;
    ir_q     = '0;
    acc_q    = '0;
    b_q      = '0;
    out_q    = '0;
    tstate_q = T1;
    run_q    = 1'b1;
  endfunction

  // One T-state of the fetch/execute cycle.
  function automatic void advance_tstate();
    logic [3:0] opc;
    opc = ir_q[7:4];
    if (run_q) begin
      case (tstate_q)
        T1: begin
          mar_q    = pc_q;
          tstate_q = T2;
        end
        T2: begin
          ir_q     = mem_q[mar_q];
          pc_q     = pc_q + 4'd1;
          tstate_q = T3;
        end
        T3: tstate_q = T4;
        T4: begin
          if (opc == OP_HLT) begin
            run_q = 1'b0;
          end else begin
            if (opc == OP_LDA || opc == OP_ADD || opc == OP_SUB) mar_q = ir_q[3:0];
            if (opc == OP_OUT) out_q = acc_q;
            tstate_q = T5;
          end
        end
        default: begin
          if (opc == OP_LDA) begin
            acc_q = mem_q[mar_q];
          end else if (opc == OP_ADD) begin
            b_q   = mem_q[mar_q];
            acc_q = acc_q + b_q;
          end else if (opc == OP_SUB) begin
            b_q   = mem_q[mar_q];
            acc_q = acc_q - b_q;
          end
          tstate_q = T1;
        end
      endcase
    end
  endfunction

  function automatic sap1_snap_t snapshot_after(input sap1_req_t req);
    case (req.req_type)
      REQ_TICK:    advance_tstate();
      REQ_WRITE:   mem_q[req.mem_address] = req.mem_data;
      REQ_RESTART: clear_cpu();
      default:     ;
    endcase
    return {pc_q, mar_q, ir_q, acc_q, b_q, out_q, run_q, tstate_q};
  endfunction

  task automatic compare_snapshot(input sap1_snap_t got, input sap1_snap_t want);
    if (got.pc_value !== want.pc_value) report_mismatch("pc_value", got.pc_value, want.pc_value);
    if (got.mar_value !== want.mar_value)
      report_mismatch("mar_value", got.mar_value, want.mar_value);
    if (got.ir_value !== want.ir_value) report_mismatch("ir_value", got.ir_value, want.ir_value);
    if (got.acc_value !== want.acc_value)
      report_mismatch("acc_value", got.acc_value, want.acc_value);
    if (got.b_value !== want.b_value) report_mismatch("b_value", got.b_value, want.b_value);
    if (got.out_value !== want.out_value)
      report_mismatch("out_value", got.out_value, want.out_value);
    if (got.cpu_running !== want.cpu_running)
      report_mismatch("cpu_running", got.cpu_running, want.cpu_running);
    if (got.phase !== want.phase) report_mismatch("phase", got.phase, want.phase);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sap1_snap_t got;
    sap1_req_t  req;
    if (!rst_ni) begin
      clear_cpu();
      foreach (mem_q[i]) mem_q[i] = '0;
      snapshots_due.delete();
      mismatch_count = 0;
      snapshot_count = 0;
    end else begin
      // Retire the response first; a request taken on this edge cannot be answered yet.
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        got = {rsp_mon.pc_value, rsp_mon.mar_value, rsp_mon.ir_value, rsp_mon.acc_value,
               rsp_mon.b_value, rsp_mon.out_value, rsp_mon.cpu_running, rsp_mon.phase};
        if (snapshots_due.size() == 0) begin
          report_mismatch("response beat with nothing pending", 1, 0);
        end else begin
          compare_snapshot(got, snapshots_due.pop_front());
        end
        snapshot_count++;
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        req = {req_mon.req_type, req_mon.mem_address, req_mon.mem_data};
        snapshots_due.push_back(snapshot_after(req));
      end
    end
  end

endmodule

FILE: tb/sap1_cpu_tstate_core_test.sv
`timescale 1ns / 100ps
// Top of the SAP-1 T-state core testbench: clock, reset, stimulus and verdict.
module sap1_cpu_tstate_core_test;
  import sap1_pkg::*;

  // The spare request code has no name in the package; the core must ignore it.
  localparam logic [1:0] ReqSpare = 2'd3;
  localparam int ItemTarget = 1400;
  // Timeout for the whole run; leave a wide margin.
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count = 0;
  int requests_sent;
  int n_ticks;
  int n_writes;
  int n_restarts;
  int n_ignored;
  int mismatches;
  int pending;
  int checked;

  sap1_req_if req_ch ();
  sap1_rsp_if rsp_ch ();

  sap1_cpu_tstate_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  sap1_snapshot_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Give up if the run hangs; a lost or stuck beat ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles with %0d snapshots still pending",
               cycle_count, pending);
      $display("sap1_cpu_tstate_core_test failed");
      $finish;
    end
  end

  // Stall the response side at random; the percentage changes with the test phase.
  always @(negedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Drive one request beat: idle at random first, then hold valid until the core
  // takes it. Leave valid high on return so back-to-back beats need no gap.
  task automatic send_request(input logic [1:0] kind, input logic [3:0] addr,
                              input logic [7:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= 2'($urandom_range(0, 3));
      req_ch.mem_address <= 4'($urandom_range(0, 15));
      req_ch.mem_data    <= 8'($urandom_range(0, 255));
      @(negedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.mem_address <= addr;
    req_ch.mem_data    <= data;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    @(negedge clk_i);
    case (kind)
      REQ_TICK:    n_ticks++;
      REQ_WRITE:   n_writes++;
      REQ_RESTART: n_restarts++;
      default:     n_ignored++;
    endcase
    if (kind != ReqSpare) requests_sent++;
  endtask

  // Bias program bytes toward real instructions so programs actually run;
  // keep some undefined opcodes and raw bytes as noise and data.
  function automatic logic [7:0] pick_instruction();
    int         roll;
    logic [3:0] opnd;
    logic [3:0] undef_op;
    roll     = $urandom_range(0, 99);
    opnd     = 4'($urandom_range(0, 15));
    undef_op = 4'($urandom_range(OP_SUB + 1, OP_OUT - 1));
    if (roll < 25) return {OP_LDA, opnd};
    if (roll < 45) return {OP_ADD, opnd};
    if (roll < 65) return {OP_SUB, opnd};
    if (roll < 75) return {OP_OUT, opnd};
    if (roll < 80) return {OP_HLT, opnd};
    if (roll < 90) return {undef_op, opnd};
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int n_load;
    int n_run;
    int roll;

    // Hold every request input at a known value from time zero.
    rst_ni             = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_TICK;
    req_ch.mem_address = '0;
    req_ch.mem_data    = '0;
    send_idle_pct      = 24;
    recv_stall_pct     = 51;
    requests_sent      = 0;
    n_ticks            = 0;
    n_writes           = 0;
    n_restarts         = 0;
    n_ignored          = 0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: load 0xFF through LDA, copy it out with OUT, then halt.
    send_request(REQ_WRITE, 4'hF, 8'hFF);
    send_request(REQ_WRITE, 4'h0, {OP_LDA, 4'hF});
    send_request(REQ_WRITE, 4'h1, {OP_OUT, 4'h0});
    send_request(REQ_WRITE, 4'h2, {OP_HLT, 4'h0});
    repeat (14) send_request(REQ_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    // Tick while halted must change nothing; a write while halted still lands.
    send_request(REQ_TICK, 4'h0, 8'h00);
    send_request(REQ_WRITE, 4'h3, {OP_SUB, 4'hF});
    // Spare request code is ignored but still answered with a snapshot.
    send_request(ReqSpare, 4'hA, 8'h55);
    // Restart clears registers and the halt, memory stays.
    send_request(REQ_RESTART, 4'h5, 8'hAA);

    // Random programs: usually restart, load some or all of memory, then run a burst of
    // ticks with the odd write, restart or spare beat mixed in.
    while (requests_sent < ItemTarget) begin
      if (requests_sent < ItemTarget / 3) begin
        send_idle_pct  = 24;
        recv_stall_pct = 51;
      end else if (requests_sent < 2 * ItemTarget / 3) begin
        send_idle_pct  = 51;
        recv_stall_pct = 24;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      if ($urandom_range(0, 99) < 85) begin
        send_request(REQ_RESTART, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end

      n_load = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : MemDepth;
      for (int i = 0; i < n_load; i++) begin
        send_request(REQ_WRITE, (n_load == MemDepth) ? 4'(i) : 4'($urandom_range(0, 15)),
                     pick_instruction());
      end

      n_run = $urandom_range(10, 80);
      repeat (n_run) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_request(REQ_WRITE, 4'($urandom_range(0, 15)), pick_instruction());
        end else if (roll < 5) begin
          send_request(ReqSpare, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end else if (roll < 6) begin
          send_request(REQ_RESTART, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end else begin
          send_request(REQ_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end
      end
    end

    // Drop valid, drain the outstanding snapshots, then watch for stray beats.
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("requests: %0d ticks, %0d writes, %0d restarts, %0d ignored",
             n_ticks, n_writes, n_restarts, n_ignored);
    $display("snapshots compared: %0d, mismatches: %0d", checked, mismatches);
    if (mismatches == 0) begin
      $display("sap1_cpu_tstate_core_test passed");
    end else begin
      $display("sap1_cpu_tstate_core_test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sap1_pkg.sv
design/sap1_if.sv
design/sap1_exec.sv
design/sap1_cpu_tstate_core.sv
design/sap1_chk.sv
tb/sap1_snapshot_checker.sv
tb/sap1_cpu_tstate_core_test.sv
